// ===== hdl/pwmss_pkg.sv =====
package pwmss_pkg;

    localparam logic [15:0] RELOAD_DEFAULT = 16'hC7C0;

    // width * 10000 / 14400 == width * 25 / 36; the divide by 36 is a
    // multiply by ceil(2^26 / 36), exact for products below 2^21
    localparam int          SCALE_SHIFT = 26;
    localparam logic [20:0] SCALE_RECIP = 21'd1864136;

    // floor(x / 10) == (x * 52429) >> 19 for any 16-bit x
    localparam logic [16:0] DIV10_MULT  = 17'd52429;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [7:0]  DP_CLEAR_MASK = 8'h7F;

    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 2 ** QUEUE_AW;

    typedef struct packed {
        logic [15:0] ticks;
        logic        wrapped;
    } t_meas;

    function automatic logic [12:0] div10(input logic [15:0] x);
        logic [32:0] p;
        begin
            p = 33'(x) * 33'(DIV10_MULT);
            return p[DIV10_SHIFT +: 13];
        end
    endfunction

    // x - q * 10 with q = floor(x / 10); only the low nibble can be non-zero
    function automatic logic [3:0] rem10(input logic [15:0] x, input logic [12:0] q);
        logic [15:0] q10;
        logic [15:0] diff;
        begin
            q10  = ({3'b000, q} << 3) + ({3'b000, q} << 1);
            diff = x - q10;
            return diff[3:0];
        end
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        begin
            unique case (digit)
                4'd0:    code = 8'hC0;
                4'd1:    code = 8'hF9;
                4'd2:    code = 8'hA4;
                4'd3:    code = 8'hB0;
                4'd4:    code = 8'h99;
                4'd5:    code = 8'h92;
                4'd6:    code = 8'h82;
                4'd7:    code = 8'hD8;
                4'd8:    code = 8'h80;
                4'd9:    code = 8'h90;
                default: code = 8'hFF;
            endcase
            return code;
        end
    endfunction

endpackage

// ===== hdl/pwmss_front.sv =====
module pwmss_front
    import pwmss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_pin_level,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_data,
    output logic        o_push,
    output t_meas       o_meas
);

    logic [15:0] r_reload;
    logic [15:0] r_tick;
    logic        r_ovf;
    logic        r_await;
    logic [15:0] r_start;
    logic        r_last;

    logic        fall;
    logic        rise;
    logic [15:0] base;

    assign fall = r_last & ~i_pin_level & ~r_await;
    assign rise = ~r_last & i_pin_level & r_await;

    // wrap correction: (end - reload) + (65536 - start), modulo 2^16
    assign base           = r_ovf ? (r_tick - r_reload) : r_tick;
    assign o_meas.ticks   = base - r_start;
    assign o_meas.wrapped = r_ovf;
    assign o_push         = i_accept & rise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reload <= RELOAD_DEFAULT;
        end else if (i_cfg_we) begin
            r_reload <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick  <= RELOAD_DEFAULT;
            r_ovf   <= 1'b0;
            r_await <= 1'b0;
            r_start <= '0;
            r_last  <= 1'b1;
        end else if (i_accept) begin
            r_last <= i_pin_level;
            if (fall) begin
                r_start <= r_tick;
                r_await <= 1'b1;
            end else if (rise) begin
                r_await <= 1'b0;
            end
            // wrap sets the flag after any capture clears it
            if (r_tick == 16'hFFFF) begin
                r_tick <= r_reload;
                r_ovf  <= 1'b1;
            end else begin
                r_tick <= r_tick + 16'd1;
                if (fall || rise) begin
                    r_ovf <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hdl/pwmss_queue.sv =====
module pwmss_queue
    import pwmss_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_meas i_data,
    input  logic  i_rd,
    output t_meas o_data,
    output logic  o_full,
    output logic  o_empty
);

    t_meas                 r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_AW:0]     r_count;

    logic do_wr;
    logic do_rd;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hdl/pwmss_back.sv =====
module pwmss_back
    import pwmss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_meas       i_meas,
    output logic        o_take,
    input  logic        pop,
    output logic        empty,
    output logic [15:0] o_pulse_ticks,
    output logic [15:0] o_scaled_width,
    output logic        o_wrapped,
    output logic [7:0]  o_seg_thousands,
    output logic [7:0]  o_seg_hundreds,
    output logic [7:0]  o_seg_tens,
    output logic [7:0]  o_seg_units
);

    logic [6:1] r_v;
    logic       en;

    t_meas       r_m1, r_m2, r_m3, r_m4, r_m5, r_m6;
    logic [20:0] r_p1;
    logic [15:0] r_sc2, r_sc3, r_sc4, r_sc5, r_sc6;
    logic [12:0] r_q3;
    logic [9:0]  r_q4;
    logic [6:0]  r_q5;
    logic [3:0]  r_d0_3, r_d0_4, r_d0_5;
    logic [3:0]  r_d1_4, r_d1_5;
    logic [3:0]  r_d2_5;
    logic [7:0]  r_seg0, r_seg1, r_seg2, r_seg3;

    logic [41:0] prod2;
    logic [12:0] q3_n, q4_n, q5_n, q6_n;
    logic [3:0]  d3_n;

    // whole pipe advances together; hold everything while the result waits
    assign en     = ~r_v[6] | pop;
    assign o_take = en & i_avail;
    assign empty  = ~r_v[6];

    assign prod2 = {21'b0, r_p1} * {21'b0, SCALE_RECIP};
    assign q3_n  = div10(r_sc2);
    assign q4_n  = div10({3'b000, r_q3});
    assign q5_n  = div10({6'b0, r_q4});
    assign q6_n  = div10({9'b0, r_q5});
    assign d3_n  = rem10({9'b0, r_q5}, q6_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[5:1], i_avail};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // times 25 by shift and add
            r_m1 <= i_meas;
            r_p1 <= ({5'b0, i_meas.ticks} << 4) + ({5'b0, i_meas.ticks} << 3)
                  + {5'b0, i_meas.ticks};

            r_m2  <= r_m1;
            r_sc2 <= prod2[SCALE_SHIFT +: 16];

            r_m3   <= r_m2;
            r_sc3  <= r_sc2;
            r_q3   <= q3_n;
            r_d0_3 <= rem10(r_sc2, q3_n);

            r_m4   <= r_m3;
            r_sc4  <= r_sc3;
            r_q4   <= q4_n[9:0];
            r_d0_4 <= r_d0_3;
            r_d1_4 <= rem10({3'b000, r_q3}, q4_n);

            r_m5   <= r_m4;
            r_sc5  <= r_sc4;
            r_q5   <= q5_n[6:0];
            r_d0_5 <= r_d0_4;
            r_d1_5 <= r_d1_4;
            r_d2_5 <= rem10({6'b0, r_q4}, q5_n);

            r_m6   <= r_m5;
            r_sc6  <= r_sc5;
            r_seg0 <= seg_code(r_d0_5);
            r_seg1 <= seg_code(r_d1_5) & DP_CLEAR_MASK;
            r_seg2 <= seg_code(r_d2_5);
            r_seg3 <= seg_code(d3_n);
        end
    end

    assign o_pulse_ticks   = r_m6.ticks;
    assign o_wrapped       = r_m6.wrapped;
    assign o_scaled_width  = r_sc6;
    assign o_seg_units     = r_seg0;
    assign o_seg_tens      = r_seg1;
    assign o_seg_hundreds  = r_seg2;
    assign o_seg_thousands = r_seg3;

endmodule

// ===== hdl/pulse_width_meter_seven_segment.sv =====
// Low-pulse width meter with seven-segment digit output.
//
// Input channel (push / full): one beat is one sample of the capture pin,
// taken once per prescaled timer tick. The internal 16-bit timer advances
// only on accepted beats, so a stalled input simply freezes time.
// Output channel (empty / pop): one beat per completed low pulse, carrying
// the width in ticks, the width in 0.1 ms units, the wrap flag and four
// active-low segment codes (decimal point lit on the tens digit).
// Config channel (i_cfg_valid / o_cfg_ready): writes the timer reload value;
// always ready, write only while no measurement is in flight.
//
// Throughput: one sample per cycle while full is low. A rising edge that
// closes a pulse is written to the queue, then passes through the six-stage
// scale and digit pipeline to the output. A four-entry queue sits between
// the edge detector and that pipeline.
// Reset (synchronous, active low) reloads the timer to 0xC7C0, empties the
// queue and the pipeline and waits for a falling edge, line idle high.
// While a result waits for pop the pipeline holds; once the queue fills,
// full rises and input beats stall.
module pulse_width_meter_seven_segment
    import pwmss_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic        i_pin_level,
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_pulse_ticks,
    output logic [15:0] o_scaled_width,
    output logic        o_wrapped,
    output logic [7:0]  o_seg_thousands,
    output logic [7:0]  o_seg_hundreds,
    output logic [7:0]  o_seg_tens,
    output logic [7:0]  o_seg_units,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic  accept;
    logic  meas_push;
    t_meas meas_in;
    t_meas meas_out;
    logic  q_empty;
    logic  take;

    // take a sample whenever the queue has room for its possible result
    assign accept      = push & ~full;
    assign o_cfg_ready = 1'b1;

    pwmss_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pin_level (i_pin_level),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (meas_push),
        .o_meas      (meas_in)
    );

    pwmss_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (meas_push),
        .i_data  (meas_in),
        .i_rd    (take),
        .o_data  (meas_out),
        .o_full  (full),
        .o_empty (q_empty)
    );

    pwmss_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_avail         (~q_empty),
        .i_meas          (meas_out),
        .o_take          (take),
        .pop             (pop),
        .empty           (empty),
        .o_pulse_ticks   (o_pulse_ticks),
        .o_scaled_width  (o_scaled_width),
        .o_wrapped       (o_wrapped),
        .o_seg_thousands (o_seg_thousands),
        .o_seg_hundreds  (o_seg_hundreds),
        .o_seg_tens      (o_seg_tens),
        .o_seg_units     (o_seg_units)
    );

endmodule

// ===== hdl/pwmss_checker.sv =====
module pwmss_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [15:0] o_pulse_ticks,
    input logic [15:0] o_scaled_width,
    input logic [7:0]  o_seg_tens
);

    // reset drains every pending result
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // a waiting beat holds until popped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_pulse_ticks)))
        else $error("result dropped or changed while stalled");

    // scaling by 25/36 never grows the value
    a_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_scaled_width <= o_pulse_ticks))
        else $error("scaled width exceeds tick width");

    // tens digit always has its decimal point lit
    a_dp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> !o_seg_tens[7])
        else $error("decimal point not lit on tens digit");

endmodule

bind pulse_width_meter_seven_segment pwmss_checker u_pwmss_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_pulse_ticks  (o_pulse_ticks),
    .o_scaled_width (o_scaled_width),
    .o_seg_tens     (o_seg_tens)
);
